FILE: hdl/ptrt_pkg.sv
// ----------------------------------------------------------------------------
// ptrt_pkg
// Shared types and constants for the periodic task release table.
// ----------------------------------------------------------------------------
package ptrt_pkg;

  // Number of task slots in the table
  localparam int SLOT_COUNT = 8;
  // Bits needed to index one slot
  localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  // Request codes
  typedef enum logic [2:0] {
    ACT_TICK    = 3'd0,
    ACT_CREATE  = 3'd1,
    ACT_DELETE  = 3'd2,
    ACT_SUSPEND = 3'd3,
    ACT_RESUME  = 3'd4
  } action_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OCCUPIED = 2'd1,
    ST_RANGE    = 2'd2
  } status_t;

  // Controller states
  typedef enum logic {
    S_IDLE = 1'b0,
    S_TICK = 1'b1
  } state_t;

  // Contents of one slot, as it travels round the ring
  typedef struct packed {
    logic        created;
    logic        resumed;
    logic [31:0] period;
    logic [31:0] countdown;
  } rec_t;

  // Write command to one cell
  typedef struct packed {
    logic        create;
    logic        del;
    logic        suspend;
    logic        resume;
    logic [31:0] period;
    logic [31:0] delay;
  } cmd_t;

endpackage

FILE: hdl/ptrt_cell.sv
// ----------------------------------------------------------------------------
// ptrt_cell
// One slot of the ring: holds a slot record, takes its neighbour's record
// while the ring rotates, and applies create, delete, suspend and resume.
// ----------------------------------------------------------------------------
module ptrt_cell
  import ptrt_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic shift,
  input  rec_t shift_in,
  input  cmd_t cmd,
  output rec_t rec
);

  // Hold or update the record; only the flags are cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      rec.created <= 1'b0;
      rec.resumed <= 1'b0;
    end else if (shift) begin
      rec <= shift_in;
    end else if (cmd.create) begin
      rec.created   <= 1'b1;
      rec.resumed   <= 1'b1;
      rec.period    <= cmd.period;
      rec.countdown <= cmd.delay;
    end else if (cmd.del) begin
      rec.created <= 1'b0;
    end else if (cmd.suspend) begin
      rec.resumed <= 1'b0;
    end else if (cmd.resume) begin
      rec.resumed <= 1'b1;
    end
  end

endmodule

FILE: hdl/ptrt_step.sv
// ----------------------------------------------------------------------------
// ptrt_step
// Shared countdown unit at the head of the ring: fires an active slot at zero and
// reloads it, counts other active slots down by one, leaves inactive ones as is.
// ----------------------------------------------------------------------------
module ptrt_step
  import ptrt_pkg::*;
(
  input  rec_t rec_in,
  output rec_t rec_out,
  output logic fire
);

  logic        active;
  logic        at_zero;
  logic [31:0] dec_src;

  // Pick reload or countdown and pass it through the single decrementer
  always_comb begin
    active  = rec_in.created && rec_in.resumed;
    at_zero = (rec_in.countdown == 32'd0);
    fire    = active && at_zero;
    dec_src = at_zero ? rec_in.period : rec_in.countdown;
    rec_out = rec_in;
    if (active) begin
      rec_out.countdown = dec_src - 32'd1;
    end
  end

endmodule

FILE: hdl/periodic_task_release_table.sv
// ----------------------------------------------------------------------------
// periodic_task_release_table
// Create, delete, suspend and resume finish at once: the result strobe comes in
// the cycle after the request is taken. A tick rotates the ring of SLOT_COUNT
// cells once through the shared countdown unit, one slot a cycle, so busy stays
// high until every slot has passed and the result follows at once. Synchronous
// reset clears all created and resumed flags and the controller. The result
// strobe lasts one cycle; the receiver cannot stall it.
// ----------------------------------------------------------------------------
module periodic_task_release_table
  import ptrt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  action,
  input  logic [7:0]  slot,
  input  logic [31:0] period,
  input  logic [31:0] delay,
  output logic        done,
  output logic [1:0]  status,
  output logic [7:0]  fired_mask
);

  state_t            state, state_next;
  logic [SLOT_W-1:0] cnt, cnt_next;
  logic [7:0]        mask_acc, mask_acc_next;
  logic              done_next;
  logic [1:0]        status_next;
  logic [7:0]        fired_mask_next;

  logic              accept;
  logic              in_range;
  logic [SLOT_W-1:0] idx;
  logic              shift;
  logic              fire;
  logic              hit_created;
  logic              do_create;
  logic              do_del;
  logic              do_suspend;
  logic              do_resume;
  logic [SLOT_COUNT-1:0] created_vec;

  rec_t rec      [SLOT_COUNT];
  rec_t shift_in [SLOT_COUNT];
  cmd_t cmd      [SLOT_COUNT];
  rec_t step_out;

  assign busy     = (state == S_TICK);
  assign accept   = start && !busy;
  assign in_range = (slot < 8'(SLOT_COUNT));
  assign idx      = slot[SLOT_W-1:0];
  assign shift    = busy;

  // Gather created flags for the occupancy check
  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      created_vec[i] = rec[i].created;
    end
    hit_created = created_vec[idx];
  end

  // Decode the request into per-cell writes
  always_comb begin
    do_create  = 1'b0;
    do_del     = 1'b0;
    do_suspend = 1'b0;
    do_resume  = 1'b0;
    if (accept && in_range) begin
      case (action)
        ACT_CREATE:  do_create  = !hit_created;
        ACT_DELETE:  do_del     = 1'b1;
        ACT_SUSPEND: do_suspend = 1'b1;
        ACT_RESUME:  do_resume  = 1'b1;
        default:     ;
      endcase
    end
    for (int i = 0; i < SLOT_COUNT; i++) begin
      cmd[i].create  = do_create  && (idx == SLOT_W'(i));
      cmd[i].del     = do_del     && (idx == SLOT_W'(i));
      cmd[i].suspend = do_suspend && (idx == SLOT_W'(i));
      cmd[i].resume  = do_resume  && (idx == SLOT_W'(i));
      cmd[i].period  = period;
      cmd[i].delay   = delay;
    end
  end

  // Build the ring: each cell takes its upper neighbour, the last takes the head
  for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_cell
    if (g == SLOT_COUNT - 1) begin : g_tail
      assign shift_in[g] = step_out;
    end else begin : g_mid
      assign shift_in[g] = rec[g+1];
    end
    ptrt_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .shift    (shift),
      .shift_in (shift_in[g]),
      .cmd      (cmd[g]),
      .rec      (rec[g])
    );
  end

  // Process the slot at the head of the ring
  ptrt_step u_step (
    .rec_in  (rec[0]),
    .rec_out (step_out),
    .fire    (fire)
  );

  // Next state and result
  always_comb begin
    state_next      = state;
    cnt_next        = cnt;
    mask_acc_next   = mask_acc;
    done_next       = 1'b0;
    status_next     = status;
    fired_mask_next = fired_mask;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (action)
            ACT_TICK: begin
              state_next    = S_TICK;
              cnt_next      = '0;
              mask_acc_next = 8'd0;
            end
            ACT_CREATE: begin
              done_next       = 1'b1;
              fired_mask_next = 8'd0;
              if (!in_range) begin
                status_next = ST_RANGE;
              end else if (hit_created) begin
                status_next = ST_OCCUPIED;
              end else begin
                status_next = ST_OK;
              end
            end
            ACT_DELETE, ACT_SUSPEND, ACT_RESUME: begin
              done_next       = 1'b1;
              fired_mask_next = 8'd0;
              status_next     = in_range ? ST_OK : ST_RANGE;
            end
            default: begin
              done_next       = 1'b1;
              fired_mask_next = 8'd0;
              status_next     = ST_OK;
            end
          endcase
        end
      end
      S_TICK: begin
        mask_acc_next = mask_acc | (8'(fire) << cnt);
        cnt_next      = cnt + SLOT_W'(1);
        if (cnt == SLOT_W'(SLOT_COUNT - 1)) begin
          state_next      = S_IDLE;
          done_next       = 1'b1;
          status_next     = ST_OK;
          fired_mask_next = mask_acc_next;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cnt        <= cnt_next;
    mask_acc   <= mask_acc_next;
    status     <= status_next;
    fired_mask <= fired_mask_next;
  end

endmodule

FILE: hdl/ptrt_checker.sv
// ----------------------------------------------------------------------------
// ptrt_checker
// Port-level checks on request and result timing of the release table.
// ----------------------------------------------------------------------------
module ptrt_checker
  import ptrt_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic [2:0]  action,
  input logic [7:0]  slot,
  input logic        done,
  input logic [1:0]  status,
  input logic [7:0]  fired_mask
);

  // A table write request is answered in the next cycle
  a_write_done : assert property (@(posedge clk) disable iff (rst)
    (start && !busy && action != ACT_TICK) |=> (done && !busy))
    else $error("table write request not answered in the next cycle");

  // A tick request makes the block busy
  a_tick_busy : assert property (@(posedge clk) disable iff (rst)
    (start && !busy && action == ACT_TICK) |=> busy)
    else $error("tick request did not raise busy");

  // An out-of-range slot gives the range status
  a_range : assert property (@(posedge clk) disable iff (rst)
    (start && !busy && slot >= 8'(SLOT_COUNT) && (action == ACT_CREATE ||
     action == ACT_DELETE || action == ACT_SUSPEND || action == ACT_RESUME))
    |=> (status == ST_RANGE))
    else $error("out-of-range slot not reported");

  // Releases come only with an ok status
  a_fired_ok : assert property (@(posedge clk) disable iff (rst)
    (done && fired_mask != 8'd0) |-> (status == ST_OK))
    else $error("released slots reported with an error status");

  // Reset leaves the block idle with no result
  a_reset : assert property (@(posedge clk)
    (!rst && $past(rst)) |-> (!done && !busy))
    else $error("block not idle after reset");

endmodule

bind periodic_task_release_table ptrt_checker u_ptrt_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .action     (action),
  .slot       (slot),
  .done       (done),
  .status     (status),
  .fired_mask (fired_mask)
);
